// ===== rtl/rea_pkg.sv =====
// Package: types, codes and constants of the radio energy accumulator.
package rea_pkg;

    localparam int NUM_ACTIVITIES_DEF = 5;
    localparam int REPORT_ITEMS = 17;

    localparam logic [2:0] MODE_RESTART = 3'd0;
    localparam logic [2:0] MODE_SET_ACT = 3'd1;
    localparam logic [2:0] MODE_START   = 3'd2;
    localparam logic [2:0] MODE_TURN    = 3'd3;
    localparam logic [2:0] MODE_CHARGE  = 3'd4;
    localparam logic [2:0] MODE_REPORT  = 3'd5;

    localparam logic [1:0] RS_TX = 2'd0;
    localparam logic [1:0] RS_RX = 2'd1;

    localparam logic [2:0] ACT_SCAN = 3'd0;
    localparam logic [2:0] ACT_LINK = 3'd1;
    localparam logic [2:0] ACT_JOIN = 3'd2;
    localparam logic [2:0] ACT_CHAN = 3'd3;
    localparam logic [2:0] ACT_BEACON = 3'd4;

    localparam logic [2:0] CFG_TX_UA     = 3'd0;
    localparam logic [2:0] CFG_RX_UA     = 3'd1;
    localparam logic [2:0] CFG_START_NC  = 3'd2;
    localparam logic [2:0] CFG_START_US  = 3'd3;
    localparam logic [2:0] CFG_TURN_NC   = 3'd4;
    localparam logic [2:0] CFG_TURN_US   = 3'd5;
    localparam logic [2:0] CFG_SLEEP_NA  = 3'd6;

    localparam logic [63:0] K1000    = 64'd1000;
    localparam logic [63:0] K1000000 = 64'd1000000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  activity;
        logic [1:0]  radio_state;
        logic [31:0] duration_us;
        logic [63:0] now_us;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  item_id;
        logic [63:0] value;
        logic        last;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHG_MUL, ST_CHG_DIV, ST_CHG_WAIT, ST_CHG_ADD,
        ST_SL_MUL, ST_SL_DIV, ST_SL_WAIT,
        ST_AVG_MUL, ST_AVG_DIV, ST_AVG_WAIT,
        ST_DUTY_MUL, ST_DUTY_DIV, ST_DUTY_WAIT,
        ST_OO0_MUL, ST_OO0_DIV, ST_OO0_WAIT,
        ST_OO1_MUL, ST_OO1_DIV, ST_OO1_WAIT,
        ST_OO2_MUL, ST_OO2_DIV, ST_OO2_WAIT,
        ST_STD_MUL, ST_STD_DIV, ST_STD_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/rea_mul.sv =====
// Multiplier: 64 by 32 product in two registered 32 by 32 halves, low 64 bits kept.
module rea_mul (
    input  logic        aclk,
    input  logic [63:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;

    always_ff @(posedge aclk) begin
        lo_reg <= {32'd0, a[31:0]} * {32'd0, b};
        hi_reg <= {32'd0, a[63:32]} * {32'd0, b};
    end

    assign p = lo_reg + {hi_reg[31:0], 32'd0};
endmodule

// ===== rtl/rea_div.sv =====
// Divider: restoring 64-bit unsigned division, one quotient bit per cycle.
module rea_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  rea_pkg::div_req_t  req,
    output rea_pkg::div_rsp_t  rsp
);
    logic [63:0] quo_reg;
    logic [64:0] rem_reg;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {rem_reg[63:0], quo_reg[63]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                quo_reg  <= req.dividend;
                rem_reg  <= 65'd0;
                den_reg  <= req.divisor;
            end else if (busy_reg) begin
                if (!diff[64]) begin
                    rem_reg <= diff;
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// ===== rtl/radio_energy_accumulator.sv =====
// Top level: radio energy accumulator with a shared multiplier and divider.
// Restart, set activity, event start and turnaround: done on acceptance, ready stays high.
// Charge: one multiply, one pass through the serial divider, then the add into the totals.
// Report: arithmetic in seven divider passes, then 17 output words.
// Throughput: one item at a time; a charge or report holds ready low until it finishes.
// Reset: synchronous active low; control, counters, totals and settings reset, not the datapath.
module radio_energy_accumulator #(
    parameter int NUM_ACTIVITIES = rea_pkg::NUM_ACTIVITIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rea_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rea_pkg::out_word_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    localparam int AW = $clog2(NUM_ACTIVITIES);

    rea_pkg::state_t state_reg, state_next;

    logic [15:0] tx_ua_reg, rx_ua_reg, start_time_reg, turn_us_reg, sleep_na_reg;
    logic [19:0] start_nc_reg, turn_nc_reg;

    logic [63:0] origin_reg, charge_reg, fixed_charge_reg, fixed_time_reg, on_time_reg;
    logic [63:0] rx_time_reg [NUM_ACTIVITIES];
    logic [63:0] tx_time_reg [NUM_ACTIVITIES];
    logic [31:0] start_cnt_reg, turn_cnt_reg;
    logic [2:0]  act_reg;

    rea_pkg::in_word_t item_reg;
    logic [63:0] elapsed_reg, total_reg, avg_reg, duty_reg, one_off_reg, steady_reg;
    logic [63:0] prod_reg;
    logic [1:0]  mwait_reg;
    logic [4:0]  idx_reg;

    logic [63:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    rea_pkg::div_req_t div_req;
    rea_pkg::div_rsp_t div_rsp;

    logic [AW-1:0] cur_act;
    logic [63:0]   out_value;
    logic          accept;

    rea_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(mul_p));
    rea_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == rea_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cur_act   = ({1'b0, act_reg} < 4'(NUM_ACTIVITIES)) ? act_reg[AW-1:0]
                                                              : rea_pkg::ACT_LINK[AW-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rea_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_data.mode == rea_pkg::MODE_CHARGE &&
                        (s_data.radio_state == rea_pkg::RS_TX ||
                         s_data.radio_state == rea_pkg::RS_RX))
                        state_next = rea_pkg::ST_CHG_MUL;
                    else if (s_data.mode == rea_pkg::MODE_REPORT)
                        state_next = rea_pkg::ST_SL_MUL;
                end
            end
            rea_pkg::ST_CHG_MUL:  if (mwait_reg == 2'd2) state_next = rea_pkg::ST_CHG_DIV;
            rea_pkg::ST_CHG_DIV:  state_next = rea_pkg::ST_CHG_WAIT;
            rea_pkg::ST_CHG_WAIT: if (div_rsp.done) state_next = rea_pkg::ST_CHG_ADD;
            rea_pkg::ST_CHG_ADD:  state_next = rea_pkg::ST_IDLE;
            rea_pkg::ST_SL_MUL:   if (mwait_reg == 2'd2) state_next = rea_pkg::ST_SL_DIV;
            rea_pkg::ST_SL_DIV:   state_next = rea_pkg::ST_SL_WAIT;
            rea_pkg::ST_SL_WAIT:  if (div_rsp.done) state_next = rea_pkg::ST_AVG_MUL;
            rea_pkg::ST_AVG_MUL:  if (mwait_reg == 2'd2) state_next = rea_pkg::ST_AVG_DIV;
            rea_pkg::ST_AVG_DIV:  state_next = rea_pkg::ST_AVG_WAIT;
            rea_pkg::ST_AVG_WAIT: if (div_rsp.done) state_next = rea_pkg::ST_DUTY_MUL;
            rea_pkg::ST_DUTY_MUL: if (mwait_reg == 2'd2) state_next = rea_pkg::ST_DUTY_DIV;
            rea_pkg::ST_DUTY_DIV: state_next = rea_pkg::ST_DUTY_WAIT;
            rea_pkg::ST_DUTY_WAIT: if (div_rsp.done) state_next = rea_pkg::ST_OO0_MUL;
            rea_pkg::ST_OO0_MUL:  if (mwait_reg == 2'd2) state_next = rea_pkg::ST_OO0_DIV;
            rea_pkg::ST_OO0_DIV:  state_next = rea_pkg::ST_OO0_WAIT;
            rea_pkg::ST_OO0_WAIT: if (div_rsp.done) state_next = rea_pkg::ST_OO1_MUL;
            rea_pkg::ST_OO1_MUL:  if (mwait_reg == 2'd2) state_next = rea_pkg::ST_OO1_DIV;
            rea_pkg::ST_OO1_DIV:  state_next = rea_pkg::ST_OO1_WAIT;
            rea_pkg::ST_OO1_WAIT: if (div_rsp.done) state_next = rea_pkg::ST_OO2_MUL;
            rea_pkg::ST_OO2_MUL:  if (mwait_reg == 2'd2) state_next = rea_pkg::ST_OO2_DIV;
            rea_pkg::ST_OO2_DIV:  state_next = rea_pkg::ST_OO2_WAIT;
            rea_pkg::ST_OO2_WAIT: if (div_rsp.done) state_next = rea_pkg::ST_STD_MUL;
            rea_pkg::ST_STD_MUL:  if (mwait_reg == 2'd2) state_next = rea_pkg::ST_STD_DIV;
            rea_pkg::ST_STD_DIV:  state_next = rea_pkg::ST_STD_WAIT;
            rea_pkg::ST_STD_WAIT: if (div_rsp.done) state_next = rea_pkg::ST_EMIT;
            rea_pkg::ST_EMIT: begin
                if (m_ready && idx_reg == 5'(rea_pkg::REPORT_ITEMS - 1))
                    state_next = rea_pkg::ST_IDLE;
            end
            default: state_next = rea_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a = 64'd0;
        mul_b = 32'd0;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = rea_pkg::K1000;
        case (state_reg)
            rea_pkg::ST_CHG_MUL: begin
                mul_a = {32'd0, item_reg.duration_us};
                mul_b = {16'd0, (item_reg.radio_state == rea_pkg::RS_TX) ? tx_ua_reg
                                                                         : rx_ua_reg};
            end
            rea_pkg::ST_SL_MUL: begin
                mul_a = elapsed_reg - on_time_reg;
                mul_b = {16'd0, sleep_na_reg};
            end
            rea_pkg::ST_AVG_MUL: begin
                mul_a = total_reg;
                mul_b = rea_pkg::K1000000[31:0];
            end
            rea_pkg::ST_DUTY_MUL: begin
                mul_a = on_time_reg;
                mul_b = rea_pkg::K1000[31:0];
            end
            rea_pkg::ST_OO0_MUL: begin
                mul_a = rx_time_reg[rea_pkg::ACT_SCAN[AW-1:0]];
                mul_b = {16'd0, rx_ua_reg};
            end
            rea_pkg::ST_OO1_MUL: begin
                mul_a = rx_time_reg[rea_pkg::ACT_JOIN[AW-1:0]];
                mul_b = {16'd0, rx_ua_reg};
            end
            rea_pkg::ST_OO2_MUL: begin
                mul_a = tx_time_reg[rea_pkg::ACT_JOIN[AW-1:0]];
                mul_b = {16'd0, tx_ua_reg};
            end
            rea_pkg::ST_STD_MUL: begin
                mul_a = total_reg - one_off_reg;
                mul_b = rea_pkg::K1000000[31:0];
            end
            rea_pkg::ST_CHG_DIV, rea_pkg::ST_OO0_DIV,
            rea_pkg::ST_OO1_DIV, rea_pkg::ST_OO2_DIV: begin
                div_req.start = 1'b1;
            end
            rea_pkg::ST_SL_DIV: begin
                div_req.start   = 1'b1;
                div_req.divisor = rea_pkg::K1000000;
            end
            rea_pkg::ST_AVG_DIV, rea_pkg::ST_DUTY_DIV, rea_pkg::ST_STD_DIV: begin
                div_req.start   = 1'b1;
                div_req.divisor = elapsed_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        case (idx_reg)
            5'd0:  out_value = elapsed_reg;
            5'd1:  out_value = on_time_reg;
            5'd2:  out_value = rx_time_reg[rea_pkg::ACT_SCAN[AW-1:0]];
            5'd3:  out_value = rx_time_reg[rea_pkg::ACT_LINK[AW-1:0]];
            5'd4:  out_value = rx_time_reg[rea_pkg::ACT_JOIN[AW-1:0]];
            5'd5:  out_value = rx_time_reg[rea_pkg::ACT_CHAN[AW-1:0]];
            5'd6:  out_value = tx_time_reg[rea_pkg::ACT_BEACON[AW-1:0]];
            5'd7:  out_value = tx_time_reg[rea_pkg::ACT_LINK[AW-1:0]];
            5'd8:  out_value = tx_time_reg[rea_pkg::ACT_JOIN[AW-1:0]];
            5'd9:  out_value = fixed_time_reg;
            5'd10: out_value = fixed_charge_reg;
            5'd11: out_value = {32'd0, start_cnt_reg};
            5'd12: out_value = {32'd0, turn_cnt_reg};
            5'd13: out_value = total_reg;
            5'd14: out_value = avg_reg;
            5'd15: out_value = duty_reg;
            5'd16: out_value = steady_reg;
            default: out_value = 64'd0;
        endcase
    end

    assign m_valid        = (state_reg == rea_pkg::ST_EMIT);
    assign m_data.item_id = idx_reg;
    assign m_data.value   = out_value;
    assign m_data.last    = (idx_reg == 5'(rea_pkg::REPORT_ITEMS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rea_pkg::ST_IDLE;
            mwait_reg <= 2'd0;
            idx_reg   <= 5'd0;
        end else begin
            state_reg <= state_next;
            if (state_next != state_reg) mwait_reg <= 2'd0;
            else if (mwait_reg != 2'd3) mwait_reg <= mwait_reg + 2'd1;
            if (state_reg == rea_pkg::ST_EMIT && m_ready) idx_reg <= idx_reg + 5'd1;
            else if (state_reg != rea_pkg::ST_EMIT) idx_reg <= 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_ua_reg      <= 16'd0;
            rx_ua_reg      <= 16'd0;
            start_nc_reg   <= 20'd949;
            start_time_reg <= 16'd993;
            turn_nc_reg    <= 20'd340;
            turn_us_reg    <= 16'd201;
            sleep_na_reg   <= 16'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                rea_pkg::CFG_TX_UA:    tx_ua_reg      <= cfg_data[15:0];
                rea_pkg::CFG_RX_UA:    rx_ua_reg      <= cfg_data[15:0];
                rea_pkg::CFG_START_NC: start_nc_reg   <= cfg_data[19:0];
                rea_pkg::CFG_START_US: start_time_reg <= cfg_data[15:0];
                rea_pkg::CFG_TURN_NC:  turn_nc_reg    <= cfg_data[19:0];
                rea_pkg::CFG_TURN_US:  turn_us_reg    <= cfg_data[15:0];
                rea_pkg::CFG_SLEEP_NA: sleep_na_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) item_reg <= s_data;
        if ((state_reg == rea_pkg::ST_CHG_MUL || state_reg == rea_pkg::ST_SL_MUL ||
             state_reg == rea_pkg::ST_AVG_MUL || state_reg == rea_pkg::ST_DUTY_MUL ||
             state_reg == rea_pkg::ST_OO0_MUL || state_reg == rea_pkg::ST_OO1_MUL ||
             state_reg == rea_pkg::ST_OO2_MUL || state_reg == rea_pkg::ST_STD_MUL) &&
            mwait_reg == 2'd1)
            prod_reg <= mul_p;
        if (accept && s_data.mode == rea_pkg::MODE_REPORT)
            elapsed_reg <= s_data.now_us - origin_reg;
        case (state_reg)
            rea_pkg::ST_SL_MUL: begin
                if (mwait_reg == 2'd0) total_reg <= charge_reg;
            end
            rea_pkg::ST_SL_WAIT: begin
                if (div_rsp.done && elapsed_reg > on_time_reg)
                    total_reg <= charge_reg + div_rsp.quotient;
            end
            rea_pkg::ST_AVG_WAIT: begin
                if (div_rsp.done)
                    avg_reg <= (elapsed_reg != 64'd0) ? div_rsp.quotient : 64'd0;
            end
            rea_pkg::ST_DUTY_WAIT: begin
                if (div_rsp.done)
                    duty_reg <= (elapsed_reg != 64'd0) ? {32'd0, div_rsp.quotient[31:0]}
                                                        : 64'd0;
            end
            rea_pkg::ST_OO0_WAIT: if (div_rsp.done) one_off_reg <= div_rsp.quotient;
            rea_pkg::ST_OO1_WAIT, rea_pkg::ST_OO2_WAIT: begin
                if (div_rsp.done) one_off_reg <= one_off_reg + div_rsp.quotient;
            end
            rea_pkg::ST_STD_WAIT: begin
                if (div_rsp.done)
                    steady_reg <= (elapsed_reg != 64'd0 && total_reg > one_off_reg)
                                  ? div_rsp.quotient : avg_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_data.mode == rea_pkg::MODE_RESTART)) begin
            origin_reg       <= aresetn ? s_data.now_us : 64'd0;
            act_reg          <= rea_pkg::ACT_LINK;
            charge_reg       <= 64'd0;
            fixed_charge_reg <= 64'd0;
            fixed_time_reg   <= 64'd0;
            on_time_reg      <= 64'd0;
            start_cnt_reg    <= 32'd0;
            turn_cnt_reg     <= 32'd0;
            for (int i = 0; i < NUM_ACTIVITIES; i++) begin
                rx_time_reg[i] <= 64'd0;
                tx_time_reg[i] <= 64'd0;
            end
        end else if (accept && s_data.mode == rea_pkg::MODE_SET_ACT) begin
            if ({1'b0, s_data.activity} < 4'(NUM_ACTIVITIES)) act_reg <= s_data.activity;
        end else if (accept && s_data.mode == rea_pkg::MODE_START) begin
            start_cnt_reg    <= start_cnt_reg + 32'd1;
            fixed_charge_reg <= fixed_charge_reg + {44'd0, start_nc_reg};
            charge_reg       <= charge_reg + {44'd0, start_nc_reg};
            fixed_time_reg   <= fixed_time_reg + {48'd0, start_time_reg};
            on_time_reg      <= on_time_reg + {48'd0, start_time_reg};
        end else if (accept && s_data.mode == rea_pkg::MODE_TURN) begin
            turn_cnt_reg     <= turn_cnt_reg + 32'd1;
            fixed_charge_reg <= fixed_charge_reg + {44'd0, turn_nc_reg};
            charge_reg       <= charge_reg + {44'd0, turn_nc_reg};
            fixed_time_reg   <= fixed_time_reg + {48'd0, turn_us_reg};
            on_time_reg      <= on_time_reg + {48'd0, turn_us_reg};
        end else if (state_reg == rea_pkg::ST_CHG_WAIT && div_rsp.done) begin
            charge_reg  <= charge_reg + div_rsp.quotient;
        end else if (state_reg == rea_pkg::ST_CHG_ADD) begin
            on_time_reg <= on_time_reg + {32'd0, item_reg.duration_us};
            if (item_reg.radio_state == rea_pkg::RS_TX)
                tx_time_reg[cur_act] <= tx_time_reg[cur_act] + {32'd0, item_reg.duration_us};
            else
                rx_time_reg[cur_act] <= rx_time_reg[cur_act] + {32'd0, item_reg.duration_us};
        end
    end
endmodule

// ===== rtl/rea_checker.sv =====
// Checker: port-level properties of the radio energy accumulator, bound to the top level.
module rea_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rea_pkg::out_word_t  m_data
);
    ap_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken during report");
    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");
    ap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last
        |=> m_valid && m_data.item_id == $past(m_data.item_id) + 5'd1)
        else $error("report words out of order");
    ap_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.item_id == 5'd16)))
        else $error("last flag misplaced");
    ap_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last |=> !m_valid)
        else $error("word after last");
endmodule

bind radio_energy_accumulator rea_checker u_rea_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// ===== tb/sv/tb_radio_energy_accumulator.sv =====
// Testbench for the radio energy accumulator: random commands checked against a predictor.
`timescale 1ns / 1ps

class energy_ledger;
    logic [63:0] tx_ua, rx_ua, start_nc, start_time, turn_nc, turn_us, sleep_na;
    logic [63:0] origin, charge, fix_nc, fix_us, on_us;
    logic [63:0] rx_us [5];
    logic [63:0] tx_us [5];
    logic [2:0]  act;
    logic [31:0] n_start, n_turn;
    rea_pkg::out_word_t pending[$];
    int          errors;

    function new();
        tx_ua = 0; rx_ua = 0; start_nc = 949; start_time = 993;
        turn_nc = 340; turn_us = 201; sleep_na = 0; errors = 0;
        clear_all(64'd0);
    endfunction

    function void clear_all(logic [63:0] t);
        origin = t; act = rea_pkg::ACT_LINK; charge = 0; fix_nc = 0; fix_us = 0; on_us = 0;
        n_start = 0; n_turn = 0;
        for (int i = 0; i < 5; i++) begin
            rx_us[i] = 0;
            tx_us[i] = 0;
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] d);
        case (idx)
            rea_pkg::CFG_TX_UA:    tx_ua = d[15:0];
            rea_pkg::CFG_RX_UA:    rx_ua = d[15:0];
            rea_pkg::CFG_START_NC: start_nc = d[19:0];
            rea_pkg::CFG_START_US: start_time = d[15:0];
            rea_pkg::CFG_TURN_NC:  turn_nc = d[19:0];
            rea_pkg::CFG_TURN_US:  turn_us = d[15:0];
            rea_pkg::CFG_SLEEP_NA: sleep_na = d[15:0];
            default: ;
        endcase
    endfunction

    function void note_word(rea_pkg::in_word_t w);
        logic [63:0] v[17];
        logic [63:0] el, sl, tot, avg, duty, oo, steady, dur;
        rea_pkg::out_word_t o;
        dur = {32'd0, w.duration_us};
        case (w.mode)
            rea_pkg::MODE_RESTART: clear_all(w.now_us);
            rea_pkg::MODE_SET_ACT: if (w.activity < 5) act = w.activity;
            rea_pkg::MODE_START: begin
                n_start++; fix_nc += start_nc; fix_us += start_time;
                charge += start_nc; on_us += start_time;
            end
            rea_pkg::MODE_TURN: begin
                n_turn++; fix_nc += turn_nc; fix_us += turn_us;
                charge += turn_nc; on_us += turn_us;
            end
            rea_pkg::MODE_CHARGE: begin
                if (w.radio_state == rea_pkg::RS_TX) begin
                    tx_us[act] += dur; charge += (tx_ua * dur) / rea_pkg::K1000; on_us += dur;
                end else if (w.radio_state == rea_pkg::RS_RX) begin
                    rx_us[act] += dur; charge += (rx_ua * dur) / rea_pkg::K1000; on_us += dur;
                end
            end
            rea_pkg::MODE_REPORT: begin
                el = w.now_us - origin;
                sl = (el > on_us) ? ((el - on_us) * sleep_na) / rea_pkg::K1000000 : 64'd0;
                tot = charge + sl;
                avg = 0; duty = 0;
                if (el != 0) begin
                    avg = (tot * rea_pkg::K1000000) / el;
                    duty = ((on_us * rea_pkg::K1000) / el) & 64'hFFFF_FFFF;
                end
                oo = (rx_us[rea_pkg::ACT_SCAN] * rx_ua) / rea_pkg::K1000
                   + (rx_us[rea_pkg::ACT_JOIN] * rx_ua) / rea_pkg::K1000
                   + (tx_us[rea_pkg::ACT_JOIN] * tx_ua) / rea_pkg::K1000;
                steady = (el != 0 && tot > oo) ? ((tot - oo) * rea_pkg::K1000000) / el : avg;
                v = '{el, on_us, rx_us[0], rx_us[1], rx_us[2], rx_us[3], tx_us[4], tx_us[1],
                      tx_us[2], fix_us, fix_nc, {32'd0, n_start}, {32'd0, n_turn}, tot, avg,
                      duty, steady};
                for (int k = 0; k < 17; k++) begin
                    o.item_id = k[4:0]; o.value = v[k]; o.last = (k == 16);
                    pending.push_back(o);
                end
            end
            default: ;
        endcase
    endfunction

    function void check_word(rea_pkg::out_word_t got);
        rea_pkg::out_word_t e;
        if (pending.size() == 0) begin
            $error("unexpected word item_id=%0d", got.item_id);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.item_id !== e.item_id) begin
            $error("item_id expected %0d actual %0d", e.item_id, got.item_id); errors++;
        end
        if (got.value !== e.value) begin
            $error("value expected %0d actual %0d", e.value, got.value); errors++;
        end
        if (got.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, got.last); errors++;
        end
    endfunction
endclass

module tb_radio_energy_accumulator;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    rea_pkg::in_word_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    rea_pkg::out_word_t m_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    longint      cycles = 0;
    int          stall_mode = 0;
    energy_ledger ledger = new();

    radio_energy_accumulator u_top (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) ledger.check_word(m_data);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge aclk) if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);

    task automatic send_word(rea_pkg::in_word_t w);
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        ledger.note_word(w);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (ledger.pending.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        ledger.write_reg(idx, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic rea_pkg::in_word_t make_word(logic [2:0] m);
        rea_pkg::in_word_t w;
        w.mode = m;
        w.activity = 3'($urandom_range(0, 7));
        w.radio_state = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(2, 3))
                                                    : 2'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: w.duration_us = 32'($urandom_range(0, 5000));
            1: w.duration_us = 32'hFFFF_FFFF;
            default: w.duration_us = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: w.now_us = {$urandom, $urandom};
            1: w.now_us = ledger.origin;
            default: w.now_us = ledger.origin + 64'($urandom_range(0, 20000000));
        endcase
        return w;
    endfunction

    task automatic random_regs(bit extreme);
        for (int i = 0; i <= rea_pkg::CFG_SLEEP_NA; i++) begin
            logic [63:0] d;
            d = extreme ? {$urandom, $urandom} : 64'($urandom_range(0, 70000));
            if (extreme && $urandom_range(0, 1)) d = 64'hFFFF_FFFF_FFFF_FFFF;
            write_reg(i[2:0], d);
        end
    endtask

    initial begin
        rea_pkg::in_word_t w;
        int burst;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        w = '0;
        w.mode = rea_pkg::MODE_REPORT;
        send_word(w);
        drain();
        random_regs(1'b0);
        for (int m = 0; m < 8; m++) begin
            w = make_word(m[2:0]);
            send_word(w);
        end
        for (int a = 0; a < 8; a++) begin
            w = make_word(rea_pkg::MODE_SET_ACT); w.activity = a[2:0]; send_word(w);
            w = make_word(rea_pkg::MODE_CHARGE); w.radio_state = a[1:0]; send_word(w);
        end
        w = make_word(rea_pkg::MODE_REPORT); w.now_us = ledger.origin; send_word(w);
        w = make_word(rea_pkg::MODE_REPORT); w.now_us = 64'hFFFF_FFFF_FFFF_FFFF; send_word(w);
        drain();
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 2) begin
                for (int i = 0; i <= rea_pkg::CFG_SLEEP_NA; i++) write_reg(i[2:0], 64'd0);
            end else begin
                random_regs(phase[0]);
            end
            w = make_word(rea_pkg::MODE_RESTART); send_word(w);
            for (int n = 0; n < 36; ) begin
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst && n < 36; b++, n++) begin
                    case ($urandom_range(0, 19))
                        0: w = make_word(rea_pkg::MODE_RESTART);
                        1, 2, 3: w = make_word(rea_pkg::MODE_SET_ACT);
                        4, 5: w = make_word(rea_pkg::MODE_START);
                        6, 7: w = make_word(rea_pkg::MODE_TURN);
                        8, 9, 10, 11, 12, 13: w = make_word(rea_pkg::MODE_CHARGE);
                        14: w = make_word(3'($urandom_range(6, 7)));
                        default: w = make_word(rea_pkg::MODE_REPORT);
                    endcase
                    send_word(w);
                end
                if (n == 18) drain();
                else repeat ($urandom_range(0, 30)) @(posedge aclk);
            end
            drain();
        end
        if (ledger.errors == 0 && ledger.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
